FILE: hw/rtl/hte_pkg.sv
// Package for the HTML text escaper: run kinds, queue entry type,
// escape sequence length and character lookup. No dependencies.
package hte_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] LEAD_BYTE = 8'hC2;
  localparam logic [7:0] NBSP_TAIL = 8'hA0;

  typedef enum logic [2:0] {
    K_NONE,
    K_BYTE,
    K_AMP,
    K_NBSP,
    K_QUOT,
    K_LT,
    K_GT
  } kind_t;

  typedef struct packed {
    logic       flush;
    kind_t      kind;
    logic [7:0] data;
    logic       done;
  } desc_t;

  function automatic logic [2:0] esc_len(input kind_t k);
    logic [2:0] n;
    case (k)
      K_BYTE:  n = 3'd1;
      K_AMP:   n = 3'd5;
      K_NBSP:  n = 3'd6;
      K_QUOT:  n = 3'd6;
      K_LT:    n = 3'd4;
      K_GT:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] esc_char(input kind_t k, input logic [2:0] idx);
    logic [7:0] c;
    c = "&";
    if (idx == 3'd0) begin
      c = "&";
    end else begin
      case (k)
        K_AMP: begin
          case (idx)
            3'd1:    c = "a";
            3'd2:    c = "m";
            3'd3:    c = "p";
            default: c = ";";
          endcase
        end
        K_NBSP: begin
          case (idx)
            3'd1:    c = "n";
            3'd2:    c = "b";
            3'd3:    c = "s";
            3'd4:    c = "p";
            default: c = ";";
          endcase
        end
        K_QUOT: begin
          case (idx)
            3'd1:    c = "q";
            3'd2:    c = "u";
            3'd3:    c = "o";
            3'd4:    c = "t";
            default: c = ";";
          endcase
        end
        K_LT: begin
          case (idx)
            3'd1:    c = "l";
            3'd2:    c = "t";
            default: c = ";";
          endcase
        end
        K_GT: begin
          case (idx)
            3'd1:    c = "g";
            3'd2:    c = "t";
            default: c = ";";
          endcase
        end
        default: c = "&";
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/hte_front.sv
// Front end: accepts input words, tracks a held C2 lead byte and
// classifies each word into a run descriptor. Depends on hte_pkg.
module hte_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          attr_mode,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_text,
  input  logic          q_full,
  output logic          q_push,
  output hte_pkg::desc_t q_desc,
  output logic          held
);
  import hte_pkg::*;

  logic held_r, held_nxt;
  logic acc;
  desc_t d;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign held     = held_r;

  always_comb begin
    d.flush  = 1'b0;
    d.kind   = K_BYTE;
    d.data   = in_byte;
    d.done   = in_end_of_text;
    held_nxt = held_r;
    if (held_r && in_byte == NBSP_TAIL) begin
      d.kind   = K_NBSP;
      held_nxt = 1'b0;
    end else begin
      d.flush  = held_r;
      held_nxt = 1'b0;
      if (in_byte == "&") begin
        d.kind = K_AMP;
      end else if (in_byte == LEAD_BYTE) begin
        if (in_end_of_text) begin
          d.kind = K_BYTE;
        end else begin
          d.kind   = K_NONE;
          held_nxt = 1'b1;
        end
      end else if (attr_mode && in_byte == "\"") begin
        d.kind = K_QUOT;
      end else if (!attr_mode && in_byte == "<") begin
        d.kind = K_LT;
      end else if (!attr_mode && in_byte == ">") begin
        d.kind = K_GT;
      end
    end
  end

  assign q_desc = d;
  assign q_push = acc && (d.flush || d.kind != K_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

FILE: hw/rtl/hte_fifo.sv
// Short descriptor queue between front and back end.
// Depends on hte_pkg for the entry type.
module hte_fifo #(
  parameter int unsigned DEPTH = hte_pkg::QueueDepthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hte_pkg::desc_t wdata,
  input  logic           pop,
  output hte_pkg::desc_t rdata,
  output logic           empty,
  output logic           full
);
  import hte_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  desc_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/hte_back.sv
// Back end: expands the head descriptor into output bytes, one per cycle
// unless out_ready stalls, into a registered output stage. Depends on hte_pkg.
module hte_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hte_pkg::desc_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_text_done
);
  import hte_pkg::*;

  logic       flushed_r;
  logic [2:0] cnt_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, done_r;

  logic       cur_flush, run_last, adv;
  logic [7:0] emit;

  assign cur_flush = head.flush && !flushed_r;

  always_comb begin
    if (cur_flush) begin
      emit     = LEAD_BYTE;
      run_last = (head.kind == K_NONE);
    end else begin
      emit     = (head.kind == K_BYTE) ? head.data : esc_char(head.kind, cnt_r);
      run_last = (cnt_r == esc_len(head.kind) - 3'd1);
    end
  end

  assign adv   = !q_empty && (!valid_r || out_ready);
  assign q_pop = adv && run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flushed_r <= 1'b0;
      cnt_r     <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
        if (run_last) begin
          flushed_r <= 1'b0;
          cnt_r     <= '0;
        end else if (cur_flush) begin
          flushed_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= emit;
      last_r <= run_last;
      done_r <= run_last && head.done;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = last_r;
  assign out_text_done = done_r;

endmodule

FILE: hw/rtl/html_text_escaper.sv
// Top level of the HTML text escaper: front classifier, descriptor queue
// and back-end expander. Depends on hte_pkg, hte_front, hte_fifo, hte_back.
//
// Takes UTF-8 text one byte per cycle while in_ready is high and emits
// the HTML-escaped stream. The back end emits one output byte at a time,
// so an escape keeps it busy for its whole sequence (up to 7 bytes with a
// flushed C2 lead byte). The front accepts a byte every cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room, so escapes only stall
// the input once the queue fills. Outputs come from a registered stage.
module html_text_escaper #(
  parameter int unsigned QUEUE_DEPTH = hte_pkg::QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_done
);
  import hte_pkg::*;

  logic  attr_mode_r;
  logic  q_full, q_empty, q_push, q_pop, held;
  desc_t q_wdata, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_mode_r <= 1'b0;
    end else if (cfg_we) begin
      attr_mode_r <= cfg_wdata;
    end
  end

  hte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .attr_mode      (attr_mode_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_desc         (q_wdata),
    .held           (held)
  );

  hte_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  hte_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("descriptor queue overflow");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_run_last)
    else $error("text_done without run_last");

  a_eot_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_text |=> !held)
    else $error("lead byte held past end of text");
`endif

endmodule
